@@ rtl/core/ksum_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ksum_pkg
// Shared types, codes and constants of the k-subarray sum core.
// ----------------------------------------------------------------------------
package ksum_pkg;

    localparam int DEF_MAX_ELEMENTS = 1024;
    localparam int DEF_MAX_K        = 20;

    localparam int IDX_W = 11;
    localparam int VAL_W = 16;
    localparam int K_W   = 5;
    localparam int OUT_W = 26;
    localparam int SC_W  = VAL_W + 1;

    localparam logic [IDX_W-1:0] ELEM_COUNT_RESET = 11'd1024;
    localparam logic [OUT_W-1:0] TOTAL_SAT        = {OUT_W{1'b1}};

    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    localparam logic REG_ELEMENT_COUNT = 1'b0;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_COPY,
        ST_SCAN,
        ST_ACC,
        ST_NEG,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic                    opcode;
        logic [IDX_W-1:0]        left;
        logic [IDX_W-1:0]        right;
        logic signed [VAL_W-1:0] value;
        logic [K_W-1:0]          k;
    } t_cmd;

    typedef struct packed {
        logic             ready;
        logic             res_valid;
        logic [OUT_W-1:0] res_data;
    } t_status;

endpackage
`default_nettype wire

@@ rtl/core/ksum_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ksum_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ksum_ram #(
    parameter int DW    = ksum_pkg::VAL_W,
    parameter int DEPTH = ksum_pkg::DEF_MAX_ELEMENTS
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [DW-1:0]            i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [DW-1:0]            o_rdata
);
    logic [DW-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

@@ rtl/core/ksum_engine.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ksum_engine
// Sequencer, value store, scratch copy and the shared adder of the core.
// ----------------------------------------------------------------------------
module ksum_engine #(
    parameter int MAX_ELEMENTS = ksum_pkg::DEF_MAX_ELEMENTS,
    parameter int MAX_K        = ksum_pkg::DEF_MAX_K
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_cmd_valid,
    input  wire ksum_pkg::t_cmd          i_cmd,
    input  wire logic [ksum_pkg::IDX_W-1:0] i_elem_count,
    output ksum_pkg::t_status            o_status
);
    import ksum_pkg::*;

    localparam int AW    = $clog2(MAX_ELEMENTS);
    localparam int CW    = AW + 1;
    localparam int UW    = (CW > IDX_W) ? CW : IDX_W;
    localparam int KW    = $clog2(MAX_K + 1);
    localparam int UKW   = (KW > K_W) ? KW : K_W;
    localparam int ACC_W = SC_W + AW;
    localparam int TOT_W = ACC_W + KW;

    localparam logic [UW-1:0]  MAX_U  = UW'(MAX_ELEMENTS);
    localparam logic [UKW-1:0] MAXK_U = UKW'(MAX_K);
    localparam logic [CW-1:0]  LAST_A = CW'(MAX_ELEMENTS - 1);

    t_state r_state, n_state;

    logic [CW-1:0]           r_clr, n_clr;
    logic [AW-1:0]           r_base, n_base;
    logic [CW-1:0]           r_len, n_len;
    logic [KW-1:0]           r_k, n_k;
    logic [KW-1:0]           r_step, n_step;
    logic [CW-1:0]           r_idx, n_idx;
    logic                    r_pv, n_pv;
    logic [CW-1:0]           r_pidx, n_pidx;
    logic signed [ACC_W-1:0] r_cur, n_cur;
    logic signed [ACC_W-1:0] r_best, n_best;
    logic [AW-1:0]           r_start, n_start;
    logic [AW-1:0]           r_lo, n_lo;
    logic [AW-1:0]           r_hi, n_hi;
    logic signed [TOT_W-1:0] r_total, n_total;
    logic signed [TOT_W-1:0] r_bt, n_bt;

    // memory ports
    logic                    st_we;
    logic [AW-1:0]           st_waddr, st_raddr;
    logic [VAL_W-1:0]        st_wdata, st_rdata;
    logic                    sc_we;
    logic [AW-1:0]           sc_waddr, sc_raddr;
    logic [SC_W-1:0]         sc_wdata, sc_rdata;

    // command decode
    logic [UW-1:0]           used, left_u, right_u;
    logic [UKW-1:0]          k_u;
    logic                    query_ok, update_ok;
    logic [UW-1:0]           len_u, base_u;

    // shared adder
    logic signed [TOT_W-1:0] add_a, add_b, add_sum;
    logic signed [SC_W-1:0]  x;
    logic signed [ACC_W-1:0] scan_cur;
    logic                    issue;
    logic                    last_beat;
    logic [TOT_W+OUT_W:0]    bt_ext;

    ksum_ram #(.DW(VAL_W), .DEPTH(MAX_ELEMENTS)) u_store (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_raddr (st_raddr),
        .o_rdata (st_rdata)
    );

    ksum_ram #(.DW(SC_W), .DEPTH(MAX_ELEMENTS)) u_scratch (
        .i_clk   (i_clk),
        .i_we    (sc_we),
        .i_waddr (sc_waddr),
        .i_wdata (sc_wdata),
        .i_raddr (sc_raddr),
        .o_rdata (sc_rdata)
    );

    always_comb begin
        left_u    = UW'(i_cmd.left);
        right_u   = UW'(i_cmd.right);
        used      = (UW'(i_elem_count) > MAX_U) ? MAX_U : UW'(i_elem_count);
        k_u       = UKW'(i_cmd.k);
        query_ok  = (left_u != '0) && (right_u <= used) && (left_u <= right_u)
                    && (k_u != '0);
        update_ok = (left_u != '0) && (left_u <= used);
        len_u     = right_u - left_u + UW'(1);
        base_u    = left_u - UW'(1);
    end

    always_comb begin
        x = signed'(sc_rdata);
        if (r_state == ST_ACC) begin
            add_a = r_total;
            add_b = TOT_W'(r_best);
        end else begin
            add_a = TOT_W'(r_cur);
            add_b = TOT_W'(x);
        end
        add_sum  = add_a + add_b;
        scan_cur = (r_cur < 0) ? ACC_W'(x) : add_sum[ACC_W-1:0];
    end

    // issue/end of the read stream for the current pass
    always_comb begin
        issue     = 1'b0;
        last_beat = 1'b0;
        case (r_state)
            ST_COPY, ST_SCAN: begin
                issue     = (r_idx < r_len);
                last_beat = r_pv && (r_pidx == r_len - CW'(1));
            end
            ST_NEG: begin
                issue     = (r_idx <= CW'(r_hi));
                last_beat = r_pv && (r_pidx == CW'(r_hi));
            end
            default: begin
                issue     = 1'b0;
                last_beat = 1'b0;
            end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: if (r_clr == LAST_A) n_state = ST_IDLE;
            ST_IDLE: begin
                if (i_cmd_valid && i_cmd.opcode == OP_QUERY) begin
                    n_state = query_ok ? ST_COPY : ST_DONE;
                end
            end
            ST_COPY: if (last_beat) n_state = ST_SCAN;
            ST_SCAN: if (last_beat) n_state = ST_ACC;
            ST_ACC:  n_state = ST_NEG;
            ST_NEG: begin
                if (last_beat) n_state = (r_step + KW'(1) == r_k) ? ST_DONE : ST_SCAN;
            end
            ST_DONE: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath registers
    always_comb begin
        n_clr   = r_clr;
        n_base  = r_base;
        n_len   = r_len;
        n_k     = r_k;
        n_step  = r_step;
        n_idx   = issue ? r_idx + CW'(1) : r_idx;
        n_pv    = issue;
        n_pidx  = r_idx;
        n_cur   = r_cur;
        n_best  = r_best;
        n_start = r_start;
        n_lo    = r_lo;
        n_hi    = r_hi;
        n_total = r_total;
        n_bt    = r_bt;
        case (r_state)
            ST_CLEAR: n_clr = r_clr + CW'(1);
            ST_IDLE: begin
                n_idx   = '0;
                n_pv    = 1'b0;
                n_step  = '0;
                n_total = '0;
                n_bt    = '0;
                n_base  = base_u[AW-1:0];
                n_len   = len_u[CW-1:0];
                n_k     = (k_u > MAXK_U) ? MAXK_U[KW-1:0] : k_u[KW-1:0];
            end
            ST_COPY: begin
                if (last_beat) begin
                    n_idx = '0;
                    n_pv  = 1'b0;
                end
            end
            ST_SCAN: begin
                if (r_pv) begin
                    if (r_pidx == '0) begin
                        n_cur   = ACC_W'(x);
                        n_best  = ACC_W'(x);
                        n_start = '0;
                        n_lo    = '0;
                        n_hi    = '0;
                    end else begin
                        n_cur = scan_cur;
                        if (r_cur < 0) n_start = r_pidx[AW-1:0];
                        if (scan_cur > r_best) begin
                            n_best = scan_cur;
                            n_lo   = (r_cur < 0) ? r_pidx[AW-1:0] : r_start;
                            n_hi   = r_pidx[AW-1:0];
                        end
                    end
                end
            end
            ST_ACC: begin
                n_total = add_sum;
                if (add_sum > r_bt) n_bt = add_sum;
                n_idx = CW'(r_lo);
                n_pv  = 1'b0;
            end
            ST_NEG: begin
                if (last_beat) begin
                    n_step = r_step + KW'(1);
                    n_idx  = '0;
                    n_pv   = 1'b0;
                end
            end
            default: begin
                n_pv = 1'b0;
            end
        endcase
    end

    // memory controls and status
    always_comb begin
        st_we    = 1'b0;
        st_waddr = r_clr[AW-1:0];
        st_wdata = '0;
        st_raddr = r_base + r_idx[AW-1:0];
        sc_we    = 1'b0;
        sc_waddr = r_pidx[AW-1:0];
        sc_wdata = SC_W'(signed'(st_rdata));
        sc_raddr = r_idx[AW-1:0];
        case (r_state)
            ST_CLEAR: st_we = 1'b1;
            ST_IDLE: begin
                st_we    = i_cmd_valid && (i_cmd.opcode == OP_UPDATE) && update_ok;
                st_waddr = base_u[AW-1:0];
                st_wdata = i_cmd.value;
            end
            ST_COPY: sc_we = r_pv;
            ST_NEG: begin
                sc_we    = r_pv;
                sc_wdata = -x;
            end
            default: sc_we = 1'b0;
        endcase
        bt_ext             = (TOT_W + OUT_W + 1)'(unsigned'(r_bt));
        o_status.ready     = (r_state == ST_IDLE);
        o_status.res_valid = (r_state == ST_DONE);
        o_status.res_data  = (bt_ext > (TOT_W + OUT_W + 1)'(TOTAL_SAT)) ? TOTAL_SAT
                             : bt_ext[OUT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr   <= '0;
            r_pv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_pv    <= n_pv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_base  <= n_base;
        r_len   <= n_len;
        r_k     <= n_k;
        r_step  <= n_step;
        r_idx   <= n_idx;
        r_pidx  <= n_pidx;
        r_cur   <= n_cur;
        r_best  <= n_best;
        r_start <= n_start;
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_total <= n_total;
        r_bt    <= n_bt;
    end
endmodule
`default_nettype wire

@@ rtl/core/k_disjoint_max_subarray_sum_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// k_disjoint_max_subarray_sum_core
// Value store with updates and greedy k-disjoint maximum subarray queries.
// ----------------------------------------------------------------------------
// One item is worked at a time. An update is written to the store in the
// cycle it is accepted. A query with effective count k (count_k capped at
// MAX_K) first copies the range into the scratch RAM, then runs k rounds of
// a scan over the range, one accumulate step and a negate pass over the
// subarray picked in that round, with a start and a finish step around them.
// Every pass streams through the scratch RAM, which has a single read port,
// one entry a cycle. A query out of range, or with count_k of zero, answers 0
// without a copy or scan. After reset the store is cleared one entry a cycle,
// during which input stalls; configuration writes are taken at any time.
// ----------------------------------------------------------------------------
module k_disjoint_max_subarray_sum_core #(
    parameter int MAX_ELEMENTS = ksum_pkg::DEF_MAX_ELEMENTS,
    parameter int MAX_K        = ksum_pkg::DEF_MAX_K
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // configuration port
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [2:0]                     paddr,
    input  wire logic [31:0]                    pwdata,
    output logic      [31:0]                    prdata,
    output logic                                pready,
    // input channel
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic                           i_opcode,
    input  wire logic [ksum_pkg::IDX_W-1:0]     i_left_index,
    input  wire logic [ksum_pkg::IDX_W-1:0]     i_right_index,
    input  wire logic signed [ksum_pkg::VAL_W-1:0] i_new_value,
    input  wire logic [ksum_pkg::K_W-1:0]       i_count_k,
    // output channel
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic      [ksum_pkg::OUT_W-1:0]     o_best_total
);
    import ksum_pkg::*;

    logic [IDX_W-1:0] r_elem_count;
    logic             r_out_valid;
    logic [OUT_W-1:0] r_best_total;
    logic             in_beat;
    logic             cfg_write;
    t_cmd             cmd;
    t_status          eng;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_ELEMENT_COUNT);
    assign prdata    = (paddr[2] == REG_ELEMENT_COUNT) ? {{(32 - IDX_W){1'b0}}, r_elem_count}
                                                       : '0;

    // hold input while the engine works or a result waits
    assign o_in_stall = !eng.ready || r_out_valid;
    assign in_beat    = i_in_valid && !o_in_stall;

    assign cmd.opcode = i_opcode;
    assign cmd.left   = i_left_index;
    assign cmd.right  = i_right_index;
    assign cmd.value  = i_new_value;
    assign cmd.k      = i_count_k;

    ksum_engine #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .MAX_K        (MAX_K)
    ) u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (in_beat),
        .i_cmd        (cmd),
        .i_elem_count (r_elem_count),
        .o_status     (eng)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elem_count <= ELEM_COUNT_RESET;
        end else if (cfg_write) begin
            r_elem_count <= pwdata[IDX_W-1:0];
        end
    end

    // result register: load on a finished query, drop once the beat is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (eng.res_valid) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (eng.res_valid) begin
            r_best_total <= eng.res_data;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_best_total = r_best_total;

    // a result never lands on top of one still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        eng.res_valid |-> !r_out_valid)
        else $error("result produced while previous result pending");

    // a query keeps the input stalled in the next cycle
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_beat && i_opcode == OP_QUERY) |=> o_in_stall)
        else $error("input accepted during a query");

    // a finished query shows up on the output
    a_result_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        eng.res_valid |=> (o_out_valid && o_best_total == $past(eng.res_data)))
        else $error("finished result not presented");
endmodule
`default_nettype wire
